// ----- hdl/euler_zyz_to_quaternion_unit_macros.svh -----
// Assertion macros for the checker file.
`ifndef EULER_ZYZ_TO_QUATERNION_UNIT_MACROS_SVH
`define EULER_ZYZ_TO_QUATERNION_UNIT_MACROS_SVH

// Concurrent assertion that is disabled while reset is active.
`define EZQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked around reset.
`define EZQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/ezq_pkg.sv -----
// Package with the shared types, constants and functions of the quaternion unit.
`timescale 1ns / 1ps
package ezq_pkg;

    localparam int CORDIC_STEPS = 31;
    localparam int CW = 34;
    localparam int PW = 2 * CW;

    typedef logic signed [CW-1:0] word_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
    } rot_t;

    typedef struct packed {
        rot_t a;
        rot_t b;
        rot_t c;
    } triple_t;

    localparam word_t GAIN_INV_Q30 = 34'sd652032874;
    localparam logic [30:0] PI_Q29 = 31'd1686629713;

    function automatic word_t atan_step(input int i);
        word_t v;
        v = '0;
        case (i)
            0: v = 34'sd843314857;
            1: v = 34'sd497837829;
            2: v = 34'sd263043837;
            3: v = 34'sd133525159;
            4: v = 34'sd67021687;
            5: v = 34'sd33543516;
            6: v = 34'sd16775851;
            7: v = 34'sd8388437;
            8: v = 34'sd4194283;
            9: v = 34'sd2097149;
            10: v = 34'sd1048576;
            default: v[30-i] = 1'b1;
        endcase
        return v;
    endfunction

    function automatic rot_t rotate(input rot_t r, input int i);
        rot_t o;
        word_t dx;
        word_t dy;
        dx = r.y >>> i;
        dy = r.x >>> i;
        if (!r.z[CW-1])
        begin
            o.x = r.x - dx;
            o.y = r.y + dy;
            o.z = r.z - atan_step(i);
        end
        else
        begin
            o.x = r.x + dx;
            o.y = r.y - dy;
            o.z = r.z + atan_step(i);
        end
        return o;
    endfunction

    function automatic word_t mul_q30(input word_t a, input word_t b);
        logic signed [PW-1:0] p;
        p = a * b;
        p = p + (PW'(1) <<< 29);
        p = p >>> 30;
        return p[CW-1:0];
    endfunction

endpackage

// ----- hdl/ezq_if.sv -----
// Valid/ready channel interfaces for angle triples and quaternions.
`timescale 1ns / 1ps
interface ezq_angle_if #(parameter int ANGLE_BITS = 16);
    logic valid;
    logic ready;
    logic signed [ANGLE_BITS-1:0] angle_alpha;
    logic signed [ANGLE_BITS-1:0] angle_beta;
    logic signed [ANGLE_BITS-1:0] angle_gamma;
    modport source (output valid, angle_alpha, angle_beta, angle_gamma, input ready);
    modport sink (input valid, angle_alpha, angle_beta, angle_gamma, output ready);
endinterface

interface ezq_quat_if #(parameter int FRACTION_BITS = 15);
    logic valid;
    logic ready;
    logic signed [FRACTION_BITS:0] quat_w;
    logic signed [FRACTION_BITS:0] quat_x;
    logic signed [FRACTION_BITS:0] quat_y;
    logic signed [FRACTION_BITS:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ----- hdl/euler_zyz_to_quaternion_unit.sv -----
// Top level: z-y-z Euler angles to unit quaternion, fully pipelined.
// The unit accepts one angle triple per clock cycle while the output is not
// stalled and returns its quaternion after a register for the half-angle scaling
// multiply, a row of 31 CORDIC cells, one per step, that rotate all three angles
// side by side, and registers for the pair products, the triple products and the
// final rounding with saturation. Every stage holds its transaction when the
// output is stalled, and an empty stage still takes data, so bubbles close up.
`timescale 1ns / 1ps
module euler_zyz_to_quaternion_unit #(
    parameter int ANGLE_BITS = 16,
    parameter int FRACTION_BITS = 15
) (
    input  logic clk,
    input  logic rst_n,
    ezq_angle_if.sink angles,
    ezq_quat_if.source quat
);
    localparam int N = ezq_pkg::CORDIC_STEPS;

    logic chain_valid [N+1];
    logic chain_ready [N+1];
    ezq_pkg::triple_t chain_data [N+1];

    ezq_prep #(.ANGLE_BITS(ANGLE_BITS)) u_prep (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(angles.valid),
        .in_ready(angles.ready),
        .alpha(angles.angle_alpha),
        .beta(angles.angle_beta),
        .gamma(angles.angle_gamma),
        .out_valid(chain_valid[0]),
        .out_ready(chain_ready[0]),
        .out_data(chain_data[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        ezq_cordic_cell #(.STEP(i)) u_cell (
            .clk(clk),
            .rst_n(rst_n),
            .in_valid(chain_valid[i]),
            .in_ready(chain_ready[i]),
            .in_data(chain_data[i]),
            .out_valid(chain_valid[i+1]),
            .out_ready(chain_ready[i+1]),
            .out_data(chain_data[i+1])
        );
    end

    ezq_combine #(.FRACTION_BITS(FRACTION_BITS)) u_combine (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(chain_valid[N]),
        .in_ready(chain_ready[N]),
        .in_data(chain_data[N]),
        .out_valid(quat.valid),
        .out_ready(quat.ready),
        .quat_w(quat.quat_w),
        .quat_x(quat.quat_x),
        .quat_y(quat.quat_y),
        .quat_z(quat.quat_z)
    );
endmodule

// ----- hdl/ezq_prep.sv -----
// Input stage that turns three binary angles into CORDIC start vectors.
`timescale 1ns / 1ps
module ezq_prep #(
    parameter int ANGLE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [ANGLE_BITS-1:0] alpha,
    input  logic signed [ANGLE_BITS-1:0] beta,
    input  logic signed [ANGLE_BITS-1:0] gamma,
    output logic out_valid,
    input  logic out_ready,
    output ezq_pkg::triple_t out_data
);
    localparam int SH = ANGLE_BITS - 1;
    localparam int MW = ANGLE_BITS + 32;

    logic valid_reg;
    logic [2:0] neg_reg;
    logic [MW-1:0] prod_reg [3];
    logic [MW-1:0] prod_next [3];
    logic signed [ANGLE_BITS-1:0] ang [3];
    ezq_pkg::word_t z [3];

    assign ang[0] = alpha;
    assign ang[1] = beta;
    assign ang[2] = gamma;
    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            logic [ANGLE_BITS-1:0] mag;
            logic [MW-1:0] r;
            mag = ang[k][ANGLE_BITS-1] ? ANGLE_BITS'(-ang[k]) : ANGLE_BITS'(ang[k]);
            prod_next[k] = MW'(mag) * MW'(ezq_pkg::PI_Q29);
            r = (prod_reg[k] + (MW'(1) << (SH - 1))) >> SH;
            z[k] = neg_reg[k] ? -ezq_pkg::word_t'(r[31:0]) : ezq_pkg::word_t'(r[31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prod_reg[k] <= prod_next[k];
                neg_reg[k] <= ang[k][ANGLE_BITS-1];
            end
        end
    end

    always_comb
    begin
        out_data.a.x = ezq_pkg::GAIN_INV_Q30;
        out_data.a.y = '0;
        out_data.a.z = z[0];
        out_data.b.x = ezq_pkg::GAIN_INV_Q30;
        out_data.b.y = '0;
        out_data.b.z = z[1];
        out_data.c.x = ezq_pkg::GAIN_INV_Q30;
        out_data.c.y = '0;
        out_data.c.z = z[2];
    end
endmodule

// ----- hdl/ezq_cordic_cell.sv -----
// One CORDIC rotation cell that advances three angle lanes by one step.
`timescale 1ns / 1ps
module ezq_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  ezq_pkg::triple_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output ezq_pkg::triple_t out_data
);
    logic valid_reg;
    ezq_pkg::triple_t data_reg;
    ezq_pkg::triple_t data_next;

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_comb
    begin
        data_next.a = ezq_pkg::rotate(in_data.a, STEP);
        data_next.b = ezq_pkg::rotate(in_data.b, STEP);
        data_next.c = ezq_pkg::rotate(in_data.c, STEP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end
endmodule

// ----- hdl/ezq_combine.sv -----
// Output stages that form the quaternion from the half-angle sines and cosines.
`timescale 1ns / 1ps
module ezq_combine #(
    parameter int FRACTION_BITS = 15
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  ezq_pkg::triple_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output logic signed [FRACTION_BITS:0] quat_w,
    output logic signed [FRACTION_BITS:0] quat_x,
    output logic signed [FRACTION_BITS:0] quat_y,
    output logic signed [FRACTION_BITS:0] quat_z
);
    localparam int PW = ezq_pkg::PW;
    localparam int SW = PW + 1;
    localparam int SH = 60 - FRACTION_BITS;
    localparam logic signed [SW-1:0] HI = (SW'(1) <<< FRACTION_BITS) - SW'(1);
    localparam logic signed [SW-1:0] LO = -(SW'(1) <<< FRACTION_BITS);

    logic [2:0] valid_reg;
    logic rdy0;
    logic rdy1;
    logic rdy2;

    ezq_pkg::word_t cb_reg, sb_reg;
    ezq_pkg::word_t pcc_reg, pss_reg, pcs_reg, psc_reg;
    logic signed [PW-1:0] m_reg [8];
    logic signed [PW-1:0] m_next [8];
    logic signed [FRACTION_BITS:0] q_reg [4];
    logic signed [FRACTION_BITS:0] q_next [4];
    logic signed [SW-1:0] sums [4];

    assign rdy2 = !valid_reg[2] || out_ready;
    assign rdy1 = !valid_reg[1] || rdy2;
    assign rdy0 = !valid_reg[0] || rdy1;
    assign in_ready = rdy0;
    assign out_valid = valid_reg[2];
    assign quat_w = q_reg[0];
    assign quat_x = q_reg[1];
    assign quat_y = q_reg[2];
    assign quat_z = q_reg[3];

    always_comb
    begin
        m_next[0] = cb_reg * pcc_reg;
        m_next[1] = cb_reg * pss_reg;
        m_next[2] = sb_reg * pcs_reg;
        m_next[3] = sb_reg * psc_reg;
        m_next[4] = sb_reg * pcc_reg;
        m_next[5] = sb_reg * pss_reg;
        m_next[6] = cb_reg * psc_reg;
        m_next[7] = cb_reg * pcs_reg;
        sums[0] = SW'(m_reg[0]) - SW'(m_reg[1]);
        sums[1] = SW'(m_reg[2]) - SW'(m_reg[3]);
        sums[2] = SW'(m_reg[4]) + SW'(m_reg[5]);
        sums[3] = SW'(m_reg[6]) + SW'(m_reg[7]);
        for (int k = 0; k < 4; k++)
        begin
            logic signed [SW-1:0] v;
            v = (sums[k] + (SW'(1) <<< (SH - 1))) >>> SH;
            if (v > HI)
            begin
                v = HI;
            end
            if (v < LO)
            begin
                v = LO;
            end
            q_next[k] = v[FRACTION_BITS:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy0)
            begin
                valid_reg[0] <= in_valid;
            end
            if (rdy1)
            begin
                valid_reg[1] <= valid_reg[0];
            end
            if (rdy2)
            begin
                valid_reg[2] <= valid_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0 && in_valid)
        begin
            cb_reg <= in_data.b.x;
            sb_reg <= in_data.b.y;
            pcc_reg <= ezq_pkg::mul_q30(in_data.a.x, in_data.c.x);
            pss_reg <= ezq_pkg::mul_q30(in_data.a.y, in_data.c.y);
            pcs_reg <= ezq_pkg::mul_q30(in_data.a.x, in_data.c.y);
            psc_reg <= ezq_pkg::mul_q30(in_data.a.y, in_data.c.x);
        end
        if (rdy1 && valid_reg[0])
        begin
            for (int k = 0; k < 8; k++)
            begin
                m_reg[k] <= m_next[k];
            end
        end
        if (rdy2 && valid_reg[1])
        begin
            for (int k = 0; k < 4; k++)
            begin
                q_reg[k] <= q_next[k];
            end
        end
    end
endmodule

// ----- hdl/ezq_checker.sv -----
// Port-level checker for the quaternion unit and its bind statement.
`timescale 1ns / 1ps
`include "euler_zyz_to_quaternion_unit_macros.svh"
module ezq_checker #(
    parameter int FRACTION_BITS = 15
) (
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic signed [FRACTION_BITS:0] quat_w,
    input logic signed [FRACTION_BITS:0] quat_x
);
    `EZQ_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "Output transaction dropped while stalled.")
    `EZQ_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(quat_w) && $stable(quat_x), "Output payload changed while stalled.")
    `EZQ_ASSERT(a_in_ready, clk, rst_n, !out_valid || out_ready |-> in_ready, "Input stalled although the output can move.")
    `EZQ_ASSERT_ALWAYS(a_reset_empty, clk, $rose(rst_n) |-> !out_valid, "Output valid right after reset.")
endmodule

bind euler_zyz_to_quaternion_unit ezq_checker #(.FRACTION_BITS(FRACTION_BITS)) u_ezq_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(angles.ready),
    .out_valid(quat.valid),
    .out_ready(quat.ready),
    .quat_w(quat.quat_w),
    .quat_x(quat.quat_x)
);
